// ===== rtl/antbl_pkg.sv =====
`timescale 1ns / 1ps

package antbl_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   // Field widths.
   localparam int ADDR_W = 32;
   localparam int NCNT_W = 8;
   localparam int TIME_W = 48;
   localparam int OCC_W  = 5;

   // Operation codes.
   localparam logic [2:0] OP_LOOKUP = 3'd0;
   localparam logic [2:0] OP_ADD    = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_UPDATE = 3'd3;
   localparam logic [2:0] OP_SELMAX = 3'd4;

   // Status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_PRESENT  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // One stored table entry.
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [NCNT_W-1:0] cnt;
      logic [TIME_W-1:0] expire;
   } entry_type;

   // Write request toward the entry memory.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        entry;
   } wr_req_type;

endpackage

// ===== rtl/antbl_entry_ram.sv =====
`timescale 1ns / 1ps

module antbl_entry_ram
   import antbl_pkg::*;
(
   input  logic             clock,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd_entry,
   input  wr_req_type       wr_req
);

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_entry_ff;

   // Single write port; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem_ff[wr_req.idx] <= wr_req.entry;
      end
   end

   // Registered read; the data for rd_idx appears on rd_entry in the following cycle.
   always_ff @(posedge clock) begin
      rd_entry_ff <= mem_ff[rd_idx];
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== rtl/aging_neighbor_table_unit.sv =====
`timescale 1ns / 1ps
// Sequence: once start is taken, the entry memory is read once per slot in a linear scan,
// with the read address issued ahead of evaluation; a finishing state then writes back and
// forms the result. A new command is taken only once the block is idle again (busy low).
// Reset: synchronous, active high; clears all valid bits and the entry count. Entry
// memory contents are not cleared. The receiver cannot stall; rsp_valid lasts one cycle.
module aging_neighbor_table_unit
   import antbl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_op,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [NCNT_W-1:0] req_neighbor_count,
   input  logic [TIME_W-1:0] req_expire_time,
   input  logic [TIME_W-1:0] req_now,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_found_address,
   output logic [NCNT_W-1:0] rsp_found_count,
   output logic [TIME_W-1:0] rsp_found_expire,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [2:0]             op_ff;
   logic [ADDR_W-1:0]      key_ff;
   logic [NCNT_W-1:0]      ncnt_ff;
   logic [TIME_W-1:0]      exp_ff;
   logic [TIME_W-1:0]      now_ff;
   logic [IDX_W-1:0]       issue_idx_ff, issue_idx_in;
   logic                   issue_on_ff, issue_on_in;
   logic [IDX_W-1:0]       eval_idx_ff;
   logic                   eval_on_ff;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic                   sel_found_ff, sel_found_in;
   logic [IDX_W-1:0]       sel_idx_ff, sel_idx_in;
   entry_type              sel_entry_ff, sel_entry_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   entry_type              rsp_entry_ff, rsp_entry_in;
   logic [OCC_W-1:0]       rsp_occ_ff, rsp_occ_in;

   entry_type  rd_entry;
   wr_req_type wr_req;
   logic       accept;
   logic       purge_en;
   logic       slot_valid;
   logic       aged;
   logic       live;
   logic       take;
   logic       better;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   antbl_entry_ram u_ram (
      .clock    (clock),
      .rd_idx   (issue_idx_ff),
      .rd_entry (rd_entry),
      .wr_req   (wr_req)
   );

   // Per-slot evaluation of the entry returned by the memory this cycle.
   always_comb begin
      purge_en   = op_ff inside {OP_LOOKUP, OP_ADD, OP_DELETE, OP_SELMAX};
      slot_valid = valid_ff[eval_idx_ff];
      aged       = eval_on_ff && slot_valid && purge_en && (rd_entry.expire <= now_ff);
      live       = eval_on_ff && slot_valid && !aged;
      better     = (rd_entry.cnt > sel_entry_ff.cnt) ||
                   (sel_found_ff && (rd_entry.cnt == sel_entry_ff.cnt) &&
                    (rd_entry.addr < sel_entry_ff.addr));
      if (op_ff == OP_SELMAX) begin
         take = live && better;
      end else begin
         take = live && !sel_found_ff && (rd_entry.addr == key_ff) &&
                (op_ff inside {OP_LOOKUP, OP_ADD, OP_DELETE, OP_UPDATE});
      end
   end

   // Sequencer, scan bookkeeping, write-back and result formation.
   always_comb begin
      state_in      = state_ff;
      issue_idx_in  = issue_idx_ff;
      issue_on_in   = issue_on_ff;
      valid_in      = valid_ff;
      total_in      = total_ff;
      sel_found_in  = sel_found_ff;
      sel_idx_in    = sel_idx_ff;
      sel_entry_in  = sel_entry_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_req        = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in      = S_SCAN;
               issue_idx_in  = '0;
               issue_on_in   = 1'b1;
               sel_found_in  = 1'b0;
               sel_entry_in  = '0;
               free_found_in = 1'b0;
            end
         end
         S_SCAN: begin
            // Address issue leads evaluation: each slot is evaluated in the cycle after its address is issued.
            if (issue_on_ff) begin
               if (issue_idx_ff == LAST_IDX) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + 1'b1;
               end
            end
            if (aged) begin
               valid_in[eval_idx_ff] = 1'b0;
               total_in              = total_ff - 1'b1;
            end
            if (take) begin
               sel_found_in = 1'b1;
               sel_idx_in   = eval_idx_ff;
               sel_entry_in = rd_entry;
            end
            if (eval_on_ff && !live && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = eval_idx_ff;
            end
            if (eval_on_ff && (eval_idx_ff == LAST_IDX)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_NOTFOUND;
            rsp_entry_in  = '0;
            case (op_ff)
               OP_LOOKUP, OP_SELMAX: begin
                  if (sel_found_ff) begin
                     rsp_status_in = ST_OK;
                     rsp_entry_in  = sel_entry_ff;
                  end
               end
               OP_ADD: begin
                  if (sel_found_ff) begin
                     rsp_status_in = ST_PRESENT;
                  end else if (!free_found_ff) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     rsp_status_in             = ST_OK;
                     rsp_entry_in.addr         = key_ff;
                     rsp_entry_in.cnt          = ncnt_ff;
                     rsp_entry_in.expire       = exp_ff;
                     wr_req.en                 = 1'b1;
                     wr_req.idx                = free_idx_ff;
                     wr_req.entry              = rsp_entry_in;
                     valid_in[free_idx_ff]     = 1'b1;
                     total_in                  = total_ff + 1'b1;
                  end
               end
               OP_DELETE: begin
                  if (sel_found_ff) begin
                     rsp_status_in        = ST_OK;
                     rsp_entry_in         = sel_entry_ff;
                     valid_in[sel_idx_ff] = 1'b0;
                     total_in             = total_ff - 1'b1;
                  end
               end
               OP_UPDATE: begin
                  if (sel_found_ff) begin
                     rsp_status_in       = ST_OK;
                     rsp_entry_in.addr   = sel_entry_ff.addr;
                     rsp_entry_in.cnt    = ncnt_ff;
                     rsp_entry_in.expire = exp_ff;
                     wr_req.en           = 1'b1;
                     wr_req.idx          = sel_idx_ff;
                     wr_req.entry        = rsp_entry_in;
                  end
               end
               default: begin
                  rsp_status_in = ST_NOTFOUND;
               end
            endcase
            rsp_occ_in = OCC_W'(total_in);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_on_ff  <= 1'b0;
         eval_on_ff   <= 1'b0;
         valid_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_on_ff  <= issue_on_in;
         eval_on_ff   <= issue_on_ff;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan bookkeeping registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         key_ff  <= req_address;
         ncnt_ff <= req_neighbor_count;
         exp_ff  <= req_expire_time;
         now_ff  <= req_now;
      end
      issue_idx_ff  <= issue_idx_in;
      eval_idx_ff   <= issue_idx_ff;
      sel_found_ff  <= sel_found_in;
      sel_idx_ff    <= sel_idx_in;
      sel_entry_ff  <= sel_entry_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_address = rsp_entry_ff.addr;
   assign rsp_found_count   = rsp_entry_ff.cnt;
   assign rsp_found_expire  = rsp_entry_ff.expire;
   assign rsp_occupancy     = rsp_occ_ff;

   // A result beat only follows the finishing cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_DONE)
      else $error("result beat without a finishing cycle");

   // The entry count tracks the valid bits whenever the table is at rest.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (total_ff == CNT_W'($countones(valid_ff))))
      else $error("entry count disagrees with valid bits");

   // Memory data is only evaluated during the scan.
   assert property (@(posedge clock) disable iff (reset)
      eval_on_ff |-> (state_ff == S_SCAN))
      else $error("slot evaluation outside the scan");

   // The finishing cycle always hands back to idle with a result beat on the ports.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (state_ff == S_IDLE) && rsp_valid)
      else $error("finishing cycle did not produce a result");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import antbl_pkg::*;

   // Op codes the block leaves unused; they must not touch the table.
   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_B = 3'd6;
   localparam logic [2:0] OP_SPARE_C = 3'd7;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam int POOL_SIZE    = 24;
   localparam int RANDOM_BEATS = 1410;
   localparam int CALM_TAIL    = 150;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [2:0]        op;
      logic [ADDR_W-1:0] addr;
      logic [NCNT_W-1:0] cnt;
      logic [TIME_W-1:0] expire;
      logic [TIME_W-1:0] now;
   } nbr_cmd_t;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] addr;
      logic [NCNT_W-1:0] cnt;
      logic [TIME_W-1:0] expire;
      logic [OCC_W-1:0]  occ;
   } nbr_reply_t;

   // One row of the directed plan; reps repeats the command with the address stepped by one.
   typedef struct packed {
      nbr_cmd_t   cmd;
      int         reps;
      logic       typed;
      nbr_reply_t want;
   } plan_row_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [2:0]        req_op = OP_LOOKUP;
   logic [ADDR_W-1:0] req_address = '0;
   logic [NCNT_W-1:0] req_neighbor_count = '0;
   logic [TIME_W-1:0] req_expire_time = '0;
   logic [TIME_W-1:0] req_now = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [ADDR_W-1:0] rsp_found_address;
   logic [NCNT_W-1:0] rsp_found_count;
   logic [TIME_W-1:0] rsp_found_expire;
   logic [OCC_W-1:0]  rsp_occupancy;

   // Shadow copy of the neighbor table.
   logic              tbl_live   [TABLE_DEPTH];
   logic [ADDR_W-1:0] tbl_addr   [TABLE_DEPTH];
   logic [NCNT_W-1:0] tbl_cnt    [TABLE_DEPTH];
   logic [TIME_W-1:0] tbl_expire [TABLE_DEPTH];
   int                tbl_total;

   nbr_reply_t        pending_replies[$];
   plan_row_t         plan[$];
   logic [ADDR_W-1:0] addr_pool[POOL_SIZE];

   int mismatches = 0;
   int replies_seen = 0;
   int beats_sent = 0;
   int aged_out = 0;
   int dup_rejects = 0;
   int full_rejects = 0;
   int misses = 0;
   int op_tally[8];

   aging_neighbor_table_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_address        (req_address),
      .req_neighbor_count (req_neighbor_count),
      .req_expire_time    (req_expire_time),
      .req_now            (req_now),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_found_address  (rsp_found_address),
      .rsp_found_count    (rsp_found_count),
      .rsp_found_expire   (rsp_found_expire),
      .rsp_occupancy      (rsp_occupancy)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Applies one command to the shadow table and returns the reply it must produce.
   function automatic nbr_reply_t table_apply(nbr_cmd_t c);
      nbr_reply_t        r;
      int                hit;
      int                slot;
      int                best;
      logic [NCNT_W-1:0] best_cnt;
      r = '0;
      r.status = ST_NOTFOUND;
      hit = -1;
      slot = -1;
      best = -1;
      best_cnt = '0;
      // Lookup, add, delete and select-max first drop entries whose expiry has been reached.
      if (c.op == OP_LOOKUP || c.op == OP_ADD || c.op == OP_DELETE || c.op == OP_SELMAX) begin
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (tbl_live[k] && tbl_expire[k] <= c.now) begin
               tbl_live[k] = 1'b0;
               tbl_total--;
               aged_out++;
            end
         end
      end
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         if (hit < 0 && tbl_live[k] && tbl_addr[k] == c.addr) hit = k;
      end
      case (c.op)
         OP_LOOKUP: begin
            slot = hit;
         end
         OP_ADD: begin
            if (hit >= 0) begin
               r.status = ST_PRESENT;
            end else begin
               for (int k = 0; k < TABLE_DEPTH; k++) begin
                  if (slot < 0 && !tbl_live[k]) slot = k;
               end
               if (slot < 0) begin
                  r.status = ST_FULL;
               end else begin
                  tbl_live[slot] = 1'b1;
                  tbl_addr[slot] = c.addr;
                  tbl_cnt[slot] = c.cnt;
                  tbl_expire[slot] = c.expire;
                  tbl_total++;
               end
            end
         end
         OP_DELETE: begin
            if (hit >= 0) begin
               slot = hit;
               tbl_live[hit] = 1'b0;
               tbl_total--;
            end
         end
         OP_UPDATE: begin
            if (hit >= 0) begin
               slot = hit;
               tbl_cnt[hit] = c.cnt;
               tbl_expire[hit] = c.expire;
            end
         end
         OP_SELMAX: begin
            // Zero counts are never chosen; ties go to the lower address.
            for (int k = 0; k < TABLE_DEPTH; k++) begin
               if (tbl_live[k] && (tbl_cnt[k] > best_cnt || (best >= 0 &&
                   tbl_cnt[k] == best_cnt && tbl_addr[k] < tbl_addr[best]))) begin
                  best = k;
                  best_cnt = tbl_cnt[k];
               end
            end
            slot = best;
         end
         default: begin
         end
      endcase
      if (slot >= 0) begin
         r.status = ST_OK;
         r.addr = tbl_addr[slot];
         r.cnt = tbl_cnt[slot];
         r.expire = tbl_expire[slot];
      end
      r.occ = OCC_W'(tbl_total);
      return r;
   endfunction

   function automatic nbr_cmd_t mk_cmd(logic [2:0] op, logic [ADDR_W-1:0] addr,
                                       logic [NCNT_W-1:0] cnt, logic [TIME_W-1:0] expire,
                                       logic [TIME_W-1:0] now);
      nbr_cmd_t c;
      c.op = op;
      c.addr = addr;
      c.cnt = cnt;
      c.expire = expire;
      c.now = now;
      return c;
   endfunction

   function automatic nbr_reply_t mk_reply(logic [1:0] status, logic [ADDR_W-1:0] addr,
                                           logic [NCNT_W-1:0] cnt,
                                           logic [TIME_W-1:0] expire, logic [OCC_W-1:0] occ);
      nbr_reply_t r;
      r.status = status;
      r.addr = addr;
      r.cnt = cnt;
      r.expire = expire;
      r.occ = occ;
      return r;
   endfunction

   task automatic put_row(input nbr_cmd_t c, input int reps, input logic typed,
                          input nbr_reply_t want);
      plan_row_t row;
      row.cmd = c;
      row.reps = reps;
      row.typed = typed;
      row.want = want;
      plan.push_back(row);
   endtask

   function automatic logic [TIME_W-1:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic string reply_text(nbr_reply_t r);
      return $sformatf("status=%0d addr=%h count=%0d expire=%h occupancy=%0d",
                       r.status, r.addr, r.cnt, r.expire, r.occ);
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   // Drives one command beat and holds it until the block takes it.
   task automatic send_beat(input nbr_cmd_t c, input logic typed, input nbr_reply_t want);
      nbr_reply_t predicted;
      req_op <= c.op;
      req_address <= c.addr;
      req_neighbor_count <= c.cnt;
      req_expire_time <= c.expire;
      req_now <= c.now;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = table_apply(c);
      pending_replies.push_back(typed ? want : predicted);
      beats_sent++;
      op_tally[c.op]++;
      if (predicted.status == ST_PRESENT) dup_rejects++;
      if (predicted.status == ST_FULL) full_rejects++;
      if (predicted.status == ST_NOTFOUND) misses++;
   endtask

   // Every reply beat is matched against the oldest outstanding prediction.
   always @(posedge clock) begin : reply_check
      nbr_reply_t got;
      nbr_reply_t want;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_found_address, rsp_found_count, rsp_found_expire,
                rsp_occupancy};
         replies_seen++;
         if (pending_replies.size() == 0) begin
            note_mismatch({"reply with nothing outstanding: ", reply_text(got)});
         end else begin
            want = pending_replies.pop_front();
            if (got !== want) begin
               note_mismatch($sformatf("reply %0d: expected %s / actual %s", replies_seen,
                                       reply_text(want), reply_text(got)));
            end
         end
      end
   end

   initial begin : stimulus
      nbr_cmd_t          c;
      int                counted;
      int                pick;
      int                next_toggle;
      int                next_rebase;
      int                waited;
      logic              idle_on;
      logic [TIME_W-1:0] clock_now;

      foreach (op_tally[i]) op_tally[i] = 0;
      for (int k = 0; k < TABLE_DEPTH; k++) tbl_live[k] = 1'b0;
      tbl_total = 0;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int k = 2; k < POOL_SIZE; k++) addr_pool[k] = $urandom;

      // Directed plan: empty table, extremes, duplicates, ties, spare codes, aging, full table.
      put_row(mk_cmd(OP_LOOKUP, 32'h0, 8'd0, 48'd0, 48'd0), 1, 1'b1,
              mk_reply(ST_NOTFOUND, 32'h0, 8'd0, 48'd0, 5'd0));
      put_row(mk_cmd(OP_SELMAX, 32'h0, 8'd0, 48'd0, 48'd0), 1, 1'b1,
              mk_reply(ST_NOTFOUND, 32'h0, 8'd0, 48'd0, 5'd0));
      put_row(mk_cmd(OP_ADD, 32'hFFFF_FFFF, 8'd255, TIME_MAX, 48'd0), 1, 1'b1,
              mk_reply(ST_OK, 32'hFFFF_FFFF, 8'd255, TIME_MAX, 5'd1));
      put_row(mk_cmd(OP_ADD, 32'h0, 8'd0, 48'd1000, 48'd0), 1, 1'b1,
              mk_reply(ST_OK, 32'h0, 8'd0, 48'd1000, 5'd2));
      put_row(mk_cmd(OP_SELMAX, 32'h0, 8'd0, 48'd0, 48'd0), 1, 1'b1,
              mk_reply(ST_OK, 32'hFFFF_FFFF, 8'd255, TIME_MAX, 5'd2));
      put_row(mk_cmd(OP_ADD, 32'hFFFF_FFFF, 8'd1, 48'd5, 48'd0), 1, 1'b1,
              mk_reply(ST_PRESENT, 32'h0, 8'd0, 48'd0, 5'd2));
      put_row(mk_cmd(OP_UPDATE, 32'h0, 8'd255, 48'd2000, TIME_MAX), 1, 1'b1,
              mk_reply(ST_OK, 32'h0, 8'd255, 48'd2000, 5'd2));
      put_row(mk_cmd(OP_SELMAX, 32'h0, 8'd0, 48'd0, 48'd1), 1, 1'b1,
              mk_reply(ST_OK, 32'h0, 8'd255, 48'd2000, 5'd2));
      put_row(mk_cmd(OP_UPDATE, 32'h1234_5678, 8'd3, 48'd9, 48'd1), 1, 1'b1,
              mk_reply(ST_NOTFOUND, 32'h0, 8'd0, 48'd0, 5'd2));
      put_row(mk_cmd(OP_SPARE_A, 32'h0, 8'd255, TIME_MAX, TIME_MAX), 1, 1'b1,
              mk_reply(ST_NOTFOUND, 32'h0, 8'd0, 48'd0, 5'd2));
      put_row(mk_cmd(OP_SPARE_B, 32'hFFFF_FFFF, 8'd1, 48'd1, TIME_MAX), 1, 1'b1,
              mk_reply(ST_NOTFOUND, 32'h0, 8'd0, 48'd0, 5'd2));
      put_row(mk_cmd(OP_SPARE_C, 32'h0, 8'd0, 48'd0, TIME_MAX), 1, 1'b1,
              mk_reply(ST_NOTFOUND, 32'h0, 8'd0, 48'd0, 5'd2));
      // Expiry equal to the current time counts as aged out.
      put_row(mk_cmd(OP_LOOKUP, 32'h0, 8'd0, 48'd0, 48'd2000), 1, 1'b1,
              mk_reply(ST_NOTFOUND, 32'h0, 8'd0, 48'd0, 5'd1));
      put_row(mk_cmd(OP_DELETE, 32'hFFFF_FFFF, 8'd0, 48'd0, 48'd2000), 1, 1'b1,
              mk_reply(ST_OK, 32'hFFFF_FFFF, 8'd255, TIME_MAX, 5'd0));
      put_row(mk_cmd(OP_DELETE, 32'hFFFF_FFFF, 8'd0, 48'd0, 48'd2000), 1, 1'b1,
              mk_reply(ST_NOTFOUND, 32'h0, 8'd0, 48'd0, 5'd0));
      put_row(mk_cmd(OP_ADD, 32'h0A00_0001, 8'd0, 48'd3000, 48'd2000), 1, 1'b1,
              mk_reply(ST_OK, 32'h0A00_0001, 8'd0, 48'd3000, 5'd1));
      put_row(mk_cmd(OP_SELMAX, 32'h0, 8'd0, 48'd0, 48'd2000), 1, 1'b1,
              mk_reply(ST_NOTFOUND, 32'h0, 8'd0, 48'd0, 5'd1));
      // Update does not age, so an already stale expiry is accepted.
      put_row(mk_cmd(OP_UPDATE, 32'h0A00_0001, 8'd9, 48'd10, 48'd2000), 1, 1'b1,
              mk_reply(ST_OK, 32'h0A00_0001, 8'd9, 48'd10, 5'd1));
      put_row(mk_cmd(OP_LOOKUP, 32'h0A00_0001, 8'd0, 48'd0, 48'd11), 1, 1'b1,
              mk_reply(ST_NOTFOUND, 32'h0, 8'd0, 48'd0, 5'd0));
      put_row(mk_cmd(OP_ADD, 32'hC0A8_0000, 8'd200, 48'd5000, 48'd11), TABLE_DEPTH, 1'b0,
              mk_reply(ST_OK, 32'h0, 8'd0, 48'd0, 5'd0));
      put_row(mk_cmd(OP_ADD, 32'h0102_0304, 8'd1, 48'd6000, 48'd11), 1, 1'b1,
              mk_reply(ST_FULL, 32'h0, 8'd0, 48'd0, 5'd16));
      put_row(mk_cmd(OP_ADD, 32'hC0A8_0005, 8'd1, 48'd6000, 48'd11), 1, 1'b1,
              mk_reply(ST_PRESENT, 32'h0, 8'd0, 48'd0, 5'd16));
      put_row(mk_cmd(OP_LOOKUP, 32'hC0A8_000F, 8'd0, 48'd0, 48'd4999), 1, 1'b1,
              mk_reply(ST_OK, 32'hC0A8_000F, 8'd200, 48'd5000, 5'd16));
      put_row(mk_cmd(OP_SELMAX, 32'h0, 8'd0, 48'd0, 48'd4999), 1, 1'b1,
              mk_reply(ST_OK, 32'hC0A8_0000, 8'd200, 48'd5000, 5'd16));
      put_row(mk_cmd(OP_LOOKUP, 32'h0, 8'd0, 48'd0, TIME_MAX), 1, 1'b1,
              mk_reply(ST_NOTFOUND, 32'h0, 8'd0, 48'd0, 5'd0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         for (int n = 0; n < plan[i].reps; n++) begin
            c = plan[i].cmd;
            c.addr = c.addr + ADDR_W'(n);
            send_beat(c, plan[i].typed, plan[i].want);
         end
      end

      // Random traffic: a slowly advancing clock, keys mostly from a small pool.
      clock_now = 48'd20000;
      idle_on = 1'b1;
      next_toggle = 60;
      next_rebase = 300;
      counted = 0;
      while (counted < RANDOM_BEATS) begin
         // Now and then let every reply come home, then move the clock somewhere new.
         if (counted >= next_rebase) begin
            next_rebase += 300;
            start <= 1'b0;
            while (pending_replies.size() != 0) @(posedge clock);
            pick = $urandom_range(0, 2);
            if (pick == 0) clock_now = rand48();
            else if (pick == 1) clock_now = TIME_MAX - 48'($urandom_range(0, 4000));
            else clock_now = 48'($urandom_range(0, 50000));
         end

         pick = $urandom_range(0, 99);
         if (pick < 20) c.op = OP_LOOKUP;
         else if (pick < 55) c.op = OP_ADD;
         else if (pick < 67) c.op = OP_DELETE;
         else if (pick < 82) c.op = OP_UPDATE;
         else if (pick < 95) c.op = OP_SELMAX;
         else c.op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));

         c.addr = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                : ADDR_W'($urandom);
         c.cnt = ($urandom_range(0, 1) == 0) ? NCNT_W'($urandom_range(0, 3))
                                             : NCNT_W'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < 2) begin
            c.now = rand48();
         end else begin
            clock_now = clock_now + 48'($urandom_range(0, 16));
            c.now = clock_now;
         end
         pick = $urandom_range(0, 99);
         if (pick < 80) c.expire = c.now + 48'($urandom_range(1, 400));
         else if (pick < 90) c.expire = c.now - 48'($urandom_range(0, 3));
         else c.expire = rand48();

         send_beat(c, 1'b0, '0);
         if (c.op <= OP_SELMAX) counted++;

         // Sender gaps come in bursts, with quiet stretches and none near the end.
         if (counted >= RANDOM_BEATS - CALM_TAIL) begin
            idle_on = 1'b0;
         end else if (counted >= next_toggle) begin
            idle_on = !idle_on;
            next_toggle = counted + $urandom_range(40, 120);
         end
         if (idle_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end

      start <= 1'b0;
      waited = 0;
      while (pending_replies.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (pending_replies.size() != 0) begin
         note_mismatch($sformatf("%0d replies never arrived", pending_replies.size()));
      end

      $display("Sent %0d beats, checked %0d replies: %0d lookup, %0d add, %0d delete,",
               beats_sent, replies_seen, op_tally[OP_LOOKUP], op_tally[OP_ADD],
               op_tally[OP_DELETE]);
      $display("%0d update, %0d select-max; %0d duplicates, %0d full, %0d misses, %0d aged out.",
               op_tally[OP_UPDATE], op_tally[OP_SELMAX], dup_rejects, full_rejects, misses,
               aged_out);
      if (mismatches == 0) begin
         $display("PASS aging_neighbor_table_unit");
      end else begin
         $display("%0d mismatches in total", mismatches);
         $display("FAIL aging_neighbor_table_unit");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      #20_000_000;
      $display("Timed out with %0d replies outstanding", pending_replies.size());
      $display("FAIL aging_neighbor_table_unit");
      $finish;
   end

endmodule
